// ===== rtl/core/ljc_pkg.sv =====
package ljc_pkg;

  localparam int unsigned FirstSites  = 16;
  localparam int unsigned SecondSites = 4;
  localparam int unsigned FsW = 4;
  localparam int unsigned SsW = 2;
  localparam int unsigned TableDepth = FirstSites * SecondSites;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CoefW = 48;
  localparam int unsigned ValW  = 64;

  // Side data widths: valid, zero flag and three coefficients through the
  // reciprocal unit; up to three more 64-bit values through a multiplier.
  localparam int unsigned RecSideW = 2 + 3*64;
  localparam int unsigned MulSideW = RecSideW + 3*64;

  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  typedef struct packed {
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] q;
  } coef_t;

  // Sign-extend Q24.24 into Q32.32.
  function automatic logic [63:0] coef_to_q32(input logic [CoefW-1:0] v);
    logic [63:0] s;
    s = {{(64-CoefW){v[CoefW-1]}}, v};
    return s << 8;
  endfunction

  function automatic logic [63:0] fx_add(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    s = x + y;
    if ((x[63] == y[63]) && (s[63] != x[63])) return x[63] ? MinNeg : MaxPos;
    return s;
  endfunction

  function automatic logic [63:0] fx_sub(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s;
    s = x - y;
    if ((x[63] != y[63]) && (s[63] != x[63])) return x[63] ? MinNeg : MaxPos;
    return s;
  endfunction

endpackage

// ===== rtl/core/ljc_mul.sv =====
// Pipelined Q32.32 signed saturating multiply, truncation toward zero.
// Four 32x32 partials, sum and result registered; side data rides along.
module ljc_mul import ljc_pkg::*; (
  input  logic                clk_i,
  input  logic [63:0]         x_i,
  input  logic [63:0]         y_i,
  input  logic [MulSideW-1:0] side_i,
  output logic [63:0]         p_o,
  output logic [MulSideW-1:0] side_o
);
  logic [63:0] ux, uy;
  logic [63:0] ll_q, lh_q, hl_q, hh_q;
  logic        neg_q, neg2_q;
  logic [127:0] mag_q;
  logic [MulSideW-1:0] s1_q, s2_q, s3_q;
  logic [63:0] res_q;
  logic [127:0] mag_d;
  logic [63:0] m;
  logic [63:0] res_d;

  assign ux = x_i[63] ? (64'd0 - x_i) : x_i;
  assign uy = y_i[63] ? (64'd0 - y_i) : y_i;

  always_ff @(posedge clk_i) begin
    ll_q  <= ux[31:0]  * uy[31:0];
    lh_q  <= ux[31:0]  * uy[63:32];
    hl_q  <= ux[63:32] * uy[31:0];
    hh_q  <= ux[63:32] * uy[63:32];
    neg_q <= x_i[63] ^ y_i[63];
    s1_q  <= side_i;
  end

  assign mag_d = {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0}
               + {hh_q, 64'd0};

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg2_q <= neg_q;
    s2_q   <= s1_q;
  end

  always_comb begin
    m = mag_q[95:32];
    if (mag_q[127:96] != 32'd0) res_d = neg2_q ? MinNeg : MaxPos;
    else if (neg2_q) res_d = (m > MinNeg) ? MinNeg : (64'd0 - m);
    else res_d = (m > MaxPos) ? MaxPos : m;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    s3_q  <= s2_q;
  end

  assign p_o    = res_q;
  assign side_o = s3_q;
endmodule

// ===== rtl/core/ljc_recip.sv =====
// Pipelined reciprocals: ir = 2^56/R, rq = isqrt(R<<32), rinv = 2^60/rq.
// Input register, 32 root stages (ir divide alongside, two bits per stage),
// then a register and 32 stages of the rinv divide.
module ljc_recip import ljc_pkg::*; (
  input  logic                clk_i,
  input  logic [31:0]         r2_i,
  input  logic [RecSideW-1:0] side_i,
  output logic [63:0]         ir_o,
  output logic [63:0]         rinv_o,
  output logic [RecSideW-1:0] side_o
);
  // Square root: 32 stages, result 32 bits. Divides: 64 quotient bits each.
  localparam int unsigned SqN = 32;
  localparam int unsigned DvN = 64;

  // Sqrt pipeline (rq), with ir divide running alongside.
  logic [63:0] sv_q  [SqN+1];
  logic [63:0] sr_q  [SqN+1];
  logic [31:0] sd_q  [SqN+1];
  logic [RecSideW:0] ss_q [SqN+1];
  // ir divide: 2^56 / R, 64-bit quotient, staged two bits/stage
  logic [63:0] ir_rem_q [SqN+1];
  logic [63:0] ir_quo_q [SqN+1];

  always_ff @(posedge clk_i) begin
    sv_q[0]     <= {r2_i, 32'd0};
    sr_q[0]     <= 64'd0;
    sd_q[0]     <= r2_i;
    ss_q[0]     <= {side_i, r2_i == 32'd0};
    ir_rem_q[0] <= 64'd0;
    ir_quo_q[0] <= 64'd0;
  end

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    logic [63:0] bitv, v, r, rem, quo, t;
    logic [64:0] rem2;
    always_comb begin
      bitv = 64'd1 << (62 - 2*g);
      v = sv_q[g];
      r = sr_q[g];
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      // two restoring divide steps on numerator 2^56 (bit 56 set)
      rem = ir_rem_q[g];
      quo = ir_quo_q[g];
      for (int k = 0; k < 2; k++) begin
        t = (2*g + k == 7) ? 64'd1 : 64'd0;
        rem2 = {rem, t[0]};
        if (sd_q[g] != 32'd0 && rem2 >= {33'd0, sd_q[g]}) begin
          rem = 64'(rem2 - {33'd0, sd_q[g]});
          quo = {quo[62:0], 1'b1};
        end else begin
          rem = rem2[63:0];
          quo = {quo[62:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      sv_q[g+1]     <= v;
      sr_q[g+1]     <= r;
      sd_q[g+1]     <= sd_q[g];
      ss_q[g+1]     <= ss_q[g];
      ir_rem_q[g+1] <= rem;
      ir_quo_q[g+1] <= quo;
    end
  end

  // After 64 quotient bits of 2^63-offset numerator we shifted in bits 63..0
  // with bit at position 63-7=56 set: quo = floor(2^56/R).
  // rinv divide: 2^60 / rq, two bits per stage.
  logic [63:0] dr_rem_q [SqN+1];
  logic [63:0] dr_quo_q [SqN+1];
  logic [31:0] dr_d_q   [SqN+1];
  logic [63:0] dr_ir_q  [SqN+1];
  logic [RecSideW:0] dr_s_q [SqN+1];

  always_ff @(posedge clk_i) begin
    dr_rem_q[0] <= 64'd0;
    dr_quo_q[0] <= 64'd0;
    dr_d_q[0]   <= sr_q[SqN][31:0];
    dr_ir_q[0]  <= ir_quo_q[SqN];
    dr_s_q[0]   <= ss_q[SqN];
  end

  for (genvar g = 0; g < SqN; g++) begin : g_dv
    logic [63:0] rem, quo, t;
    logic [64:0] rem2;
    always_comb begin
      rem = dr_rem_q[g];
      quo = dr_quo_q[g];
      for (int k = 0; k < 2; k++) begin
        t = (2*g + k == 3) ? 64'd1 : 64'd0;
        rem2 = {rem, t[0]};
        if (dr_d_q[g] != 32'd0 && rem2 >= {33'd0, dr_d_q[g]}) begin
          rem = 64'(rem2 - {33'd0, dr_d_q[g]});
          quo = {quo[62:0], 1'b1};
        end else begin
          rem = rem2[63:0];
          quo = {quo[62:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      dr_rem_q[g+1] <= rem;
      dr_quo_q[g+1] <= quo;
      dr_d_q[g+1]   <= dr_d_q[g];
      dr_ir_q[g+1]  <= dr_ir_q[g];
      dr_s_q[g+1]   <= dr_s_q[g];
    end
  end

  logic unused;
  assign unused = ^{sv_q[SqN], sr_q[SqN][63:32], sd_q[SqN], ir_rem_q[SqN],
                    dr_rem_q[SqN], dr_d_q[SqN]} ^ (DvN == 64);

  assign ir_o   = dr_s_q[SqN][0] ? MaxPos : dr_ir_q[SqN];
  assign rinv_o = dr_s_q[SqN][0] ? MaxPos : dr_quo_q[SqN];
  assign side_o = dr_s_q[SqN][RecSideW:1];
endmodule

// ===== rtl/core/ljc_table.sv =====
// Site-pair coefficient memory; synchronous read, registered output.
module ljc_table import ljc_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  coef_t           wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output coef_t           rdata_o
);
  coef_t mem_q [TableDepth];
  coef_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;
endmodule

// ===== rtl/core/lj_coulomb_pair_force_unit.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | cmd, sites, dist_sq, coefficients
// out     | output    | out_valid_o/out_ready_i | force, energies, zero flag
//
// One transaction per cycle sustained while in_ready_o stays high. A load writes
// the coefficient memory and gives no result; an evaluate result passes the memory
// read, the square root and two dividers (two quotient bits a stage), then a
// five-level chain of multipliers, before it is written to the output FIFO.
// Reset clears only the valid pipe and output FIFO; the memory is left as is.
// Stalls: in_ready_o drops when the output FIFO cannot hold every result still
// in flight, so out_ready_i low never loses a result.
module lj_coulomb_pair_force_unit import ljc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [FsW-1:0]     first_site_i,
  input  logic [SsW-1:0]     second_site_i,
  input  logic [31:0]        dist_sq_i,
  input  logic signed [47:0] coef_repulsive_i,
  input  logic signed [47:0] coef_dispersive_i,
  input  logic signed [47:0] coef_charge_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] force_factor_o,
  output logic signed [63:0] pair_energy_o,
  output logic signed [63:0] coulomb_energy_o,
  output logic               zero_distance_o
);
  // Valid-pipe depth: reciprocal unit plus 5 mul levels; final add/sub is
  // combinational in front of the FIFO.
  localparam int unsigned RecLat = 66;
  localparam int unsigned MulLat = 3;
  localparam int unsigned VLat = RecLat + 5*MulLat;
  localparam int unsigned FifoD = 128;
  localparam int unsigned FifoW = $clog2(FifoD);

  logic in_fire, ok, ld, ev;
  logic [IdxW-1:0] idx;
  coef_t wr, rd;

  assign in_fire = in_valid_i && in_ready_o;
  assign ok  = (32'(first_site_i) < FirstSites) && (32'(second_site_i) < SecondSites);
  assign idx = IdxW'(32'(first_site_i) * SecondSites + 32'(second_site_i));
  assign ld  = in_fire && (cmd_i == CmdLoad) && ok;
  assign ev  = in_fire && (cmd_i == CmdEval);
  assign wr  = '{a: coef_repulsive_i, b: coef_dispersive_i, q: coef_charge_i};

  ljc_table u_tab (.clk_i, .we_i(ld), .waddr_i(idx), .wdata_i(wr),
                   .raddr_i(idx), .rdata_o(rd));

  // Stage 0 register after memory read (memory read lands here).
  // vp_q is the reset valid pipe that matches the datapath latency.
  logic        v0_q, ok0_q;
  logic [31:0] r2_0_q;
  logic [VLat-1:0] vp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vp_q <= '0;
    end else begin
      v0_q <= ev;
      vp_q <= {vp_q[VLat-2:0], v0_q};
    end
  end
  always_ff @(posedge clk_i) begin
    ok0_q  <= ok;
    r2_0_q <= dist_sq_i;
  end
  // Same-entry load right after evaluate cannot hit: read happens same cycle
  // as accept, before any later write.

  logic [63:0] a0, b0, q0;
  assign a0 = ok0_q ? coef_to_q32(rd.a) : 64'd0;
  assign b0 = ok0_q ? coef_to_q32(rd.b) : 64'd0;
  assign q0 = ok0_q ? coef_to_q32(rd.q) : 64'd0;

  localparam int unsigned SW = RecSideW;
  logic [SW-1:0] s_r;
  logic [63:0] ir, rinv;
  ljc_recip u_rec (.clk_i, .r2_i(r2_0_q),
    .side_i({v0_q, r2_0_q == 32'd0, a0, b0, q0}),
    .ir_o(ir), .rinv_o(rinv), .side_o(s_r));

  logic [63:0] q1;
  assign q1 = s_r[63:0];

  // Side outputs of the helper multipliers carry nothing.
  logic [MulSideW-1:0] m1b_side, m3b_side, m3c_side, m4b_side;

  // Level 1: ir*ir, q*rinv
  localparam int unsigned S1W = SW + 64;
  logic [63:0] ir2, ec;
  logic [MulSideW-1:0] s1;
  logic [S1W-1:0] s1b;
  ljc_mul u_m1 (.clk_i, .x_i(ir), .y_i(ir), .side_i(MulSideW'({s_r, ir})),
                .p_o(ir2), .side_o(s1));
  ljc_mul u_m1b (.clk_i, .x_i(q1), .y_i(rinv), .side_i('0),
                 .p_o(ec), .side_o(m1b_side));
  assign s1b = s1[S1W-1:0];

  // Level 2: ir6 = ir2*ir, carry ec
  localparam int unsigned S2W = S1W + 64;
  logic [63:0] ir6, ir_2;
  logic [MulSideW-1:0] s2;
  ljc_mul u_m2 (.clk_i, .x_i(ir2), .y_i(s1b[63:0]),
                .side_i(MulSideW'({s1b, ec})), .p_o(ir6), .side_o(s2));
  logic [63:0] ec2, a2, b2;
  assign ec2  = s2[63:0];
  assign ir_2 = s2[127:64];
  assign a2   = s2[64+64+191:64+64+128];
  assign b2   = s2[64+64+127:64+64+64];

  // Level 3: A*ir6, 12A*ir6, ec*ir
  logic [63:0] aiv, a12iv, ecir;
  logic [MulSideW-1:0] s3;
  ljc_mul u_m3 (.clk_i, .x_i(a2), .y_i(ir6),
                .side_i({s2[S2W-1:0], ir6}), .p_o(aiv), .side_o(s3));
  ljc_mul u_m3b (.clk_i, .x_i(a2 * 64'd12), .y_i(ir6),
                 .side_i('0), .p_o(a12iv), .side_o(m3b_side));
  ljc_mul u_m3c (.clk_i, .x_i(ec2), .y_i(ir_2), .side_i('0),
                 .p_o(ecir), .side_o(m3c_side));
  logic [63:0] ir6_3, ec3, ir3, b3, t, u;
  assign ir6_3 = s3[63:0];
  assign ec3   = s3[127:64];
  assign ir3   = s3[191:128];
  assign b3    = s3[64*3+127:64*3+64];
  assign t = fx_sub(aiv, b3);
  assign u = fx_sub(b3 * 64'd6, a12iv);

  // Level 4: t*ir6, u*ir6
  localparam int unsigned S4W = 2 + 64*3;
  logic [63:0] tiv, uiv;
  logic [MulSideW-1:0] s4;
  ljc_mul u_m4 (.clk_i, .x_i(t), .y_i(ir6_3),
    .side_i(MulSideW'({s3[S2W+63], s3[S2W+62], ec3, ir3, ecir})),
    .p_o(tiv), .side_o(s4));
  ljc_mul u_m4b (.clk_i, .x_i(u), .y_i(ir6_3), .side_i('0),
                 .p_o(uiv), .side_o(m4b_side));
  logic [63:0] eg;
  assign eg = fx_add(tiv, s4[191:128]);

  // Level 5: uiv*ir
  localparam int unsigned S5W = 2 + 64*3;
  logic [63:0] uir;
  logic [MulSideW-1:0] s5;
  ljc_mul u_m5 (.clk_i, .x_i(uiv), .y_i(s4[127:64]),
    .side_i(MulSideW'({s4[S4W-1:S4W-2], s4[191:128], eg, s4[63:0]})),
    .p_o(uir), .side_o(s5));

  logic res_v, res_z;
  logic [63:0] res_f, res_e, res_c;
  assign res_v = vp_q[VLat-1];
  assign res_z = s5[S5W-2];
  assign res_c = s5[191:128];
  assign res_e = s5[127:64];
  assign res_f = fx_sub(uir, s5[63:0]);

  // Output FIFO, credit-based. Registered read of the next head entry, with
  // the incoming result forwarded when it lands on that entry.
  typedef struct packed {
    logic [63:0] f, e, c;
    logic        z;
  } res_t;
  res_t fifo_q [FifoD];
  res_t res_w, head_q;
  logic [FifoW-1:0] wp_q, rp_q, rp_nxt;
  logic [FifoW:0]   cnt_q, infl_q;
  logic out_fire;

  assign out_fire    = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign in_ready_o  = (32'(cnt_q) + 32'(infl_q)) < (FifoD - 1);
  assign rp_nxt      = rp_q + FifoW'(out_fire);
  assign res_w       = '{f: res_f, e: res_e, c: res_c, z: res_z};

  always_ff @(posedge clk_i) begin
    if (res_v) fifo_q[wp_q] <= res_w;
    if (res_v && (wp_q == rp_nxt)) head_q <= res_w;
    else head_q <= fifo_q[rp_nxt];
  end
  assign force_factor_o   = head_q.f;
  assign pair_energy_o    = head_q.e;
  assign coulomb_energy_o = head_q.c;
  assign zero_distance_o  = head_q.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; infl_q <= '0;
    end else begin
      if (res_v) wp_q <= wp_q + 1'b1;
      rp_q   <= rp_nxt;
      cnt_q  <= cnt_q + (FifoW+1)'(res_v) - (FifoW+1)'(out_fire);
      infl_q <= infl_q + (FifoW+1)'(ev) - (FifoW+1)'(res_v);
    end
  end

  logic unused;
  assign unused = ^{s1[MulSideW-1:S1W], s2[MulSideW-1:S2W], s4[MulSideW-1:S4W],
                    s5[MulSideW-1:S5W-1], m1b_side, m3b_side, m3c_side, m4b_side};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoD) else $error("fifo overflow");
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> cnt_q != '0) else $error("pop when empty");
  a_res_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |-> infl_q != '0) else $error("result without request");
endmodule
